[sv/yuvrot_pkg.sv]
// Shared types, constants and helper functions for the YUV to RGB565 rotation block.
// No dependencies; every other file refers to it by scoped names.
package yuvrot_pkg;

	// Field widths of the stream and configuration ports.
	localparam int SAMPLE_W = 8;
	localparam int POS_W    = 10;
	localparam int CFG_W    = 11;
	localparam int PIX_W    = 16;
	localparam int ADDR_W   = 20;
	localparam int IDX_W    = 2;

	// Default frame size limit and register reset values.
	localparam int MAX_DIM_DEF = 1024;
	localparam logic [CFG_W-1:0] DIM_RESET = 11'd240;

	// Width of the signed channel sums; the largest one, blue, needs 19 bits.
	localparam int SUM_W = 20;

	// BT.601 studio range coefficients, scaled by 256.
	localparam logic signed [SUM_W-1:0] K_Y     = 20'sd298;
	localparam logic signed [SUM_W-1:0] K_RV    = 20'sd409;
	localparam logic signed [SUM_W-1:0] K_GU    = 20'sd100;
	localparam logic signed [SUM_W-1:0] K_GV    = 20'sd208;
	localparam logic signed [SUM_W-1:0] K_BU    = 20'sd516;
	localparam logic signed [SUM_W-1:0] K_ROUND = 20'sd128;
	localparam logic signed [8:0]       Y_OFS   = 9'sd16;
	localparam logic signed [8:0]       C_OFS   = 9'sd128;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_ROTATION   = 2'd0,
		REG_SRC_WIDTH  = 2'd1,
		REG_SRC_HEIGHT = 2'd2
	} reg_idx_t;

	// Rotation codes.
	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_90   = 2'd1,
		ROT_180  = 2'd2,
		ROT_270  = 2'd3
	} rot_t;

	// Load enables of the three pipeline stages.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_ctl_t;

	// Drop the fraction of a rounded channel sum and clamp it to 0..255.
	function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] t);
		logic [SUM_W-10:0] q;
		q = t[SUM_W-2:8];
		if (t < 0) begin
			return '0;
		end else if (q > (SUM_W-9)'(255)) begin
			return 8'hFF;
		end else begin
			return q[SAMPLE_W-1:0];
		end
	endfunction

endpackage

[sv/yuvrot_ctrl.sv]
// Valid bits and stage enables of the three-stage pipeline.
// Depends on yuvrot_pkg for the stage enable struct.
module yuvrot_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output yuvrot_pkg::pipe_ctl_t ctl
);

	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	// A stage takes a new word when it is empty or its word moves on.
	assign adv3 = !valid_s3 || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign ctl.en1  = adv1;
	assign ctl.en2  = adv2;
	assign ctl.en3  = adv3;
	assign in_ready  = adv1;
	assign out_valid = valid_s3;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

endmodule

[sv/yuvrot_color.sv]
// Color datapath: BT.601 studio range YCbCr to clamped RGB, packed as RGB565.
// Depends on yuvrot_pkg for coefficients, the clamp function and stage enables.
module yuvrot_color (
	input  logic                                clk,
	input  yuvrot_pkg::pipe_ctl_t               ctl,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]     luma,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]     chroma_blue,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]     chroma_red,
	output logic [yuvrot_pkg::PIX_W-1:0]        pixel_value
);

	localparam int SW = yuvrot_pkg::SUM_W;

	logic signed [8:0]    y_off, u_off, v_off;
	logic signed [SW-1:0] c_s1, rv_s1, gu_s1, gv_s1, bu_s1;
	logic signed [SW-1:0] r_sum_s2, g_sum_s2, b_sum_s2;
	logic [yuvrot_pkg::SAMPLE_W-1:0] r8, g8, b8;
	logic [yuvrot_pkg::PIX_W-1:0] pixel_s3;

	// Remove the studio range offsets.
	assign y_off = $signed({1'b0, luma})        - yuvrot_pkg::Y_OFS;
	assign u_off = $signed({1'b0, chroma_blue}) - yuvrot_pkg::C_OFS;
	assign v_off = $signed({1'b0, chroma_red})  - yuvrot_pkg::C_OFS;

	// Stage 1: constant products.
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			c_s1  <= SW'(y_off) * yuvrot_pkg::K_Y;
			rv_s1 <= SW'(v_off) * yuvrot_pkg::K_RV;
			gu_s1 <= SW'(u_off) * yuvrot_pkg::K_GU;
			gv_s1 <= SW'(v_off) * yuvrot_pkg::K_GV;
			bu_s1 <= SW'(u_off) * yuvrot_pkg::K_BU;
		end
	end

	// Stage 2: channel sums with the rounding term.
	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			r_sum_s2 <= c_s1 + rv_s1 + yuvrot_pkg::K_ROUND;
			g_sum_s2 <= c_s1 - gu_s1 - gv_s1 + yuvrot_pkg::K_ROUND;
			b_sum_s2 <= c_s1 + bu_s1 + yuvrot_pkg::K_ROUND;
		end
	end

	// Stage 3: clamp each channel and keep its top 5, 6 and 5 bits.
	assign r8 = yuvrot_pkg::clamp_channel(r_sum_s2);
	assign g8 = yuvrot_pkg::clamp_channel(g_sum_s2);
	assign b8 = yuvrot_pkg::clamp_channel(b_sum_s2);

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			pixel_s3 <= {r8[7:3], g8[7:2], b8[7:3]};
		end
	end

	assign pixel_value = pixel_s3;

endmodule

[sv/yuvrot_addr.sv]
// Address datapath: frame check, rotation of the position and linear destination index.
// Depends on yuvrot_pkg for widths, rotation codes and stage enables.
module yuvrot_addr #(
	parameter int MAX_DIM = yuvrot_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  yuvrot_pkg::pipe_ctl_t             ctl,
	input  yuvrot_pkg::rot_t                  rotation,
	input  logic [yuvrot_pkg::CFG_W-1:0]      src_width,
	input  logic [yuvrot_pkg::CFG_W-1:0]      src_height,
	input  logic [yuvrot_pkg::POS_W-1:0]      src_col,
	input  logic [yuvrot_pkg::POS_W-1:0]      src_row,
	output logic [yuvrot_pkg::POS_W-1:0]      dest_col,
	output logic [yuvrot_pkg::POS_W-1:0]      dest_row,
	output logic [yuvrot_pkg::ADDR_W-1:0]     dest_addr,
	output logic                              outside_frame
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CW    = (DIM_W > yuvrot_pkg::POS_W) ? DIM_W : yuvrot_pkg::POS_W;
	localparam int EXT_W = (CW > yuvrot_pkg::CFG_W) ? CW : yuvrot_pkg::CFG_W;
	localparam int PW    = 2 * CW;

	logic [CW-1:0] w, h, sx, sy, dx, dy, rot_w;
	logic          outside;

	logic [CW-1:0] dx_s1, dy_s1, rotw_s1;
	logic          outside_s1;
	logic [PW-1:0] prod_s2;
	logic [CW-1:0] dx_s2, dy_s2;
	logic          outside_s2;
	logic [PW-1:0] addr_full;

	logic [yuvrot_pkg::POS_W-1:0]  col_s3, row_s3;
	logic [yuvrot_pkg::ADDR_W-1:0] addr_s3;
	logic                          outside_s3;

	// Frame sizes above the limit saturate to it.
	assign w = (EXT_W'(src_width) > EXT_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(src_width);
	assign h = (EXT_W'(src_height) > EXT_W'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(src_height);
	assign sx = CW'(src_col);
	assign sy = CW'(src_row);
	assign outside = (sx >= w) || (sy >= h);

	// Rotated position and the width of the rotated frame.
	always_comb begin
		unique case (rotation)
			yuvrot_pkg::ROT_90: begin
				dx    = h - CW'(1) - sy;
				dy    = sx;
				rot_w = h;
			end
			yuvrot_pkg::ROT_180: begin
				dx    = w - CW'(1) - sx;
				dy    = h - CW'(1) - sy;
				rot_w = w;
			end
			yuvrot_pkg::ROT_270: begin
				dx    = sy;
				dy    = w - CW'(1) - sx;
				rot_w = h;
			end
			default: begin
				dx    = sx;
				dy    = sy;
				rot_w = w;
			end
		endcase
	end

	// Stage 1: frame check and rotation.
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			dx_s1      <= dx;
			dy_s1      <= dy;
			rotw_s1    <= rot_w;
			outside_s1 <= outside;
		end
	end

	// Stage 2: row times rotated width.
	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			prod_s2    <= PW'(dy_s1) * PW'(rotw_s1);
			dx_s2      <= dx_s1;
			dy_s2      <= dy_s1;
			outside_s2 <= outside_s1;
		end
	end

	// Stage 3: add the column; a position outside the frame gives zeros.
	assign addr_full = prod_s2 + PW'(dx_s2);

	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			outside_s3 <= outside_s2;
			if (outside_s2) begin
				col_s3  <= '0;
				row_s3  <= '0;
				addr_s3 <= '0;
			end else begin
				col_s3  <= dx_s2[yuvrot_pkg::POS_W-1:0];
				row_s3  <= dy_s2[yuvrot_pkg::POS_W-1:0];
				addr_s3 <= addr_full[yuvrot_pkg::ADDR_W-1:0];
			end
		end
	end

	assign dest_col      = col_s3;
	assign dest_row      = row_s3;
	assign dest_addr     = addr_s3;
	assign outside_frame = outside_s3;

endmodule

[sv/yuv420_to_rgb565_rotate.sv]
// YUV to RGB565 converter with 0/90/180/270 degree rotation of the pixel position.
// An accepted input word moves to its output word through the
// three register stages; throughput is one word per cycle while out_ready stays high.
// Empty stages fill while the output stalls. Reset empties the pipeline and sets
// rotation to none and both frame sizes to 240. Uses yuvrot_pkg, yuvrot_ctrl,
// yuvrot_color and yuvrot_addr.
module yuv420_to_rgb565_rotate #(
	parameter int MAX_DIM = yuvrot_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [yuvrot_pkg::IDX_W-1:0]      cfg_index,
	input  logic [yuvrot_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]   luma,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]   chroma_blue,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]   chroma_red,
	input  logic [yuvrot_pkg::POS_W-1:0]      src_col,
	input  logic [yuvrot_pkg::POS_W-1:0]      src_row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [yuvrot_pkg::PIX_W-1:0]      pixel_value,
	output logic [yuvrot_pkg::POS_W-1:0]      dest_col,
	output logic [yuvrot_pkg::POS_W-1:0]      dest_row,
	output logic [yuvrot_pkg::ADDR_W-1:0]     dest_addr,
	output logic                              outside_frame
);

	yuvrot_pkg::rot_t                 rotation_q;
	logic [yuvrot_pkg::CFG_W-1:0]     src_width_q;
	logic [yuvrot_pkg::CFG_W-1:0]     src_height_q;
	yuvrot_pkg::pipe_ctl_t            ctl;

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q   <= yuvrot_pkg::ROT_NONE;
			src_width_q  <= yuvrot_pkg::DIM_RESET;
			src_height_q <= yuvrot_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (yuvrot_pkg::reg_idx_t'(cfg_index))
				yuvrot_pkg::REG_ROTATION:   rotation_q   <= yuvrot_pkg::rot_t'(cfg_wdata[1:0]);
				yuvrot_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata;
				yuvrot_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Pipeline control.
	yuvrot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Color conversion.
	yuvrot_color u_color (
		.clk         (clk),
		.ctl         (ctl),
		.luma        (luma),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.pixel_value (pixel_value)
	);

	// Destination position and address.
	yuvrot_addr #(
		.MAX_DIM (MAX_DIM)
	) u_addr (
		.clk           (clk),
		.ctl           (ctl),
		.rotation      (rotation_q),
		.src_width     (src_width_q),
		.src_height    (src_height_q),
		.src_col       (src_col),
		.src_row       (src_row),
		.dest_col      (dest_col),
		.dest_row      (dest_row),
		.dest_addr     (dest_addr),
		.outside_frame (outside_frame)
	);

endmodule

[sv/yuvrot_checker.sv]
// Port-level checks of the YUV to RGB565 rotation block, bound to its top level.
// Depends on yuvrot_pkg for port widths.
module yuvrot_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [yuvrot_pkg::PIX_W-1:0]      pixel_value,
	input logic [yuvrot_pkg::POS_W-1:0]      dest_col,
	input logic [yuvrot_pkg::POS_W-1:0]      dest_row,
	input logic [yuvrot_pkg::ADDR_W-1:0]     dest_addr,
	input logic                              outside_frame
);

	// A stalled output word stays.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled output word keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_value) && $stable(dest_addr)
			&& $stable(dest_col) && $stable(dest_row) && $stable(outside_frame))
		else $error("output payload changed while stalled");

	// Input is refused only when every stage is full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused with room in the pipeline");

	// A pixel outside the frame has a zero destination.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outside_frame |-> dest_col == '0 && dest_row == '0 && dest_addr == '0)
		else $error("outside pixel has a nonzero destination");

endmodule

bind yuv420_to_rgb565_rotate yuvrot_checker u_checker (.*);

[tb/rgb565_rotate_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for yuv420_to_rgb565_rotate: it tracks the register writes, predicts every
// pixel word from the accepted input word and compares the output words in order.
// Depends on yuvrot_pkg for the port widths and the register and rotation codes.
module rgb565_rotate_checker #(
	parameter int MAX_DIM = yuvrot_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [yuvrot_pkg::IDX_W-1:0]      cfg_index,
	input  logic [yuvrot_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]   luma,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]   chroma_blue,
	input  logic [yuvrot_pkg::SAMPLE_W-1:0]   chroma_red,
	input  logic [yuvrot_pkg::POS_W-1:0]      src_col,
	input  logic [yuvrot_pkg::POS_W-1:0]      src_row,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [yuvrot_pkg::PIX_W-1:0]      pixel_value,
	input  logic [yuvrot_pkg::POS_W-1:0]      dest_col,
	input  logic [yuvrot_pkg::POS_W-1:0]      dest_row,
	input  logic [yuvrot_pkg::ADDR_W-1:0]     dest_addr,
	input  logic                              outside_frame,
	output int                                fail_count,
	output int                                pending
);

	// One predicted or observed output word.
	typedef struct packed {
		logic [yuvrot_pkg::PIX_W-1:0]  pix;
		logic [yuvrot_pkg::POS_W-1:0]  col;
		logic [yuvrot_pkg::POS_W-1:0]  row;
		logic [yuvrot_pkg::ADDR_W-1:0] addr;
		logic                          outside;
	} pixel_word_t;

	// Local copy of the configuration registers.
	yuvrot_pkg::rot_t             rot_q;
	logic [yuvrot_pkg::CFG_W-1:0] width_q;
	logic [yuvrot_pkg::CFG_W-1:0] height_q;

	pixel_word_t pending_pixels[$];
	pixel_word_t seen;
	pixel_word_t want;

	// Round a channel sum scaled by 256, drop the fraction and clamp to 0..255.
	function automatic int sat_channel(input int sum);
		int t;
		t = sum + 128;
		if (t < 0) begin
			return 0;
		end
		t = t >> 8;
		return (t > 255) ? 255 : t;
	endfunction

	// Color conversion and rotated placement of one source pixel.
	function automatic pixel_word_t convert_pixel(
			input logic [yuvrot_pkg::SAMPLE_W-1:0] y, cb, cr,
			input logic [yuvrot_pkg::POS_W-1:0] col, row,
			input yuvrot_pkg::rot_t rot, input int w, input int h);
		pixel_word_t res;
		int c, u, v, r, g, b;
		int ew, eh, dx, dy, rw;
		int addr;
		ew = (w > MAX_DIM) ? MAX_DIM : w;
		eh = (h > MAX_DIM) ? MAX_DIM : h;
		// BT.601 studio range coefficients scaled by 256.
		c = 298 * (int'(y) - 16);
		u = int'(cb) - 128;
		v = int'(cr) - 128;
		r = sat_channel(c + 409 * v);
		g = sat_channel(c - 100 * u - 208 * v);
		b = sat_channel(c + 516 * u);
		res.pix = {r[7:3], g[7:2], b[7:3]};
		res.outside = (int'(col) >= ew) || (int'(row) >= eh);
		dx = 0;
		dy = 0;
		rw = ew;
		// Positions outside the frame keep a zero destination.
		if (!res.outside) begin
			case (rot)
				yuvrot_pkg::ROT_90: begin
					dx = eh - 1 - int'(row);
					dy = int'(col);
					rw = eh;
				end
				yuvrot_pkg::ROT_180: begin
					dx = ew - 1 - int'(col);
					dy = eh - 1 - int'(row);
				end
				yuvrot_pkg::ROT_270: begin
					dx = int'(row);
					dy = ew - 1 - int'(col);
					rw = eh;
				end
				default: begin
					dx = int'(col);
					dy = int'(row);
				end
			endcase
		end
		addr = dy * rw + dx;
		res.col = dx[yuvrot_pkg::POS_W-1:0];
		res.row = dy[yuvrot_pkg::POS_W-1:0];
		res.addr = addr[yuvrot_pkg::ADDR_W-1:0];
		return res;
	endfunction

	// Track register writes, queue predictions and compare output words in order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q = yuvrot_pkg::ROT_NONE;
			width_q = yuvrot_pkg::DIM_RESET;
			height_q = yuvrot_pkg::DIM_RESET;
			pending_pixels.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (yuvrot_pkg::reg_idx_t'(cfg_index))
					yuvrot_pkg::REG_ROTATION:   rot_q = yuvrot_pkg::rot_t'(cfg_wdata[1:0]);
					yuvrot_pkg::REG_SRC_WIDTH:  width_q = cfg_wdata;
					yuvrot_pkg::REG_SRC_HEIGHT: height_q = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pending_pixels.push_back(convert_pixel(luma, chroma_blue, chroma_red,
					src_col, src_row, rot_q, int'(width_q), int'(height_q)));
			end
			if (out_valid && out_ready) begin
				seen = {pixel_value, dest_col, dest_row, dest_addr, outside_frame};
				if (pending_pixels.size() == 0) begin
					$display("%0t: output word with no input pending:", $time);
					$display("%0t:   pixel=%h col=%0d row=%0d addr=%0d outside=%0d",
						$time, seen.pix, seen.col, seen.row, seen.addr, seen.outside);
					fail_count++;
				end else begin
					want = pending_pixels.pop_front();
					if (seen !== want) begin
						$display("%0t: word mismatch: expected pixel=%h col=%0d row=%0d",
							$time, want.pix, want.col, want.row);
						$display("%0t:   expected addr=%0d outside=%0d",
							$time, want.addr, want.outside);
						$display("%0t:   actual pixel=%h col=%0d row=%0d",
							$time, seen.pix, seen.col, seen.row);
						$display("%0t:   actual addr=%0d outside=%0d",
							$time, seen.addr, seen.outside);
						fail_count++;
					end
				end
			end
			pending = pending_pixels.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench for yuv420_to_rgb565_rotate: clock, reset, register setup and the
// pixel stream with random idling on both sides. Depends on yuvrot_pkg and the checker.
module tb_top;

	localparam int LATENCY     = 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 36;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [yuvrot_pkg::IDX_W-1:0]    cfg_index = '0;
	logic [yuvrot_pkg::CFG_W-1:0]    cfg_wdata = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [yuvrot_pkg::SAMPLE_W-1:0] luma = '0;
	logic [yuvrot_pkg::SAMPLE_W-1:0] chroma_blue = '0;
	logic [yuvrot_pkg::SAMPLE_W-1:0] chroma_red = '0;
	logic [yuvrot_pkg::POS_W-1:0]    src_col = '0;
	logic [yuvrot_pkg::POS_W-1:0]    src_row = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [yuvrot_pkg::PIX_W-1:0]    pixel_value;
	logic [yuvrot_pkg::POS_W-1:0]    dest_col;
	logic [yuvrot_pkg::POS_W-1:0]    dest_row;
	logic [yuvrot_pkg::ADDR_W-1:0]   dest_addr;
	logic                            outside_frame;

	int fail_count;
	int pending;
	int cycles = 0;
	int sender_idle = 0;
	int recv_stall = 0;
	int hold_seq = 0;
	int cur_w = 240;
	int cur_h = 240;

	always #2 clk = ~clk;

	yuv420_to_rgb565_rotate uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red),
		.src_col(src_col), .src_row(src_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_value(pixel_value), .dest_col(dest_col), .dest_row(dest_row),
		.dest_addr(dest_addr), .outside_frame(outside_frame)
	);

	rgb565_rotate_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red),
		.src_col(src_col), .src_row(src_row),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_value(pixel_value), .dest_col(dest_col), .dest_row(dest_row),
		.dest_addr(dest_addr), .outside_frame(outside_frame),
		.fail_count(fail_count), .pending(pending)
	);

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[yuv420_to_rgb565_rotate] ERROR");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off when requested.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Sample value with the extremes weighted up.
	function automatic logic [yuvrot_pkg::SAMPLE_W-1:0] pick_sample();
		int sel;
		int raw;
		sel = $urandom_range(7);
		if (sel == 0) begin
			return '0;
		end
		if (sel == 1) begin
			return '1;
		end
		raw = $urandom;
		return raw[yuvrot_pkg::SAMPLE_W-1:0];
	endfunction

	// Position along one axis: mostly inside the frame, with edges and strays.
	function automatic logic [yuvrot_pkg::POS_W-1:0] pick_pos(input int dim);
		int sel;
		int ed;
		int p;
		sel = $urandom_range(9);
		ed = (dim > yuvrot_pkg::MAX_DIM_DEF) ? yuvrot_pkg::MAX_DIM_DEF : dim;
		if (ed == 0 || sel == 0) begin
			p = $urandom;
		end else if (sel == 1) begin
			p = ed - 1;
		end else if (sel == 2) begin
			p = 0;
		end else if (sel == 3 && ed < yuvrot_pkg::MAX_DIM_DEF) begin
			p = ed;
		end else begin
			p = $urandom_range(ed - 1);
		end
		return p[yuvrot_pkg::POS_W-1:0];
	endfunction

	// Frame dimension: mostly even and legal, sometimes anything the register holds.
	function automatic int pick_dim();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(2047);
		end
		return 2 * $urandom_range(512, 1);
	endfunction

	// Offer one input word, idling first at the current rate, and wait for acceptance.
	task automatic send_pixel(input logic [yuvrot_pkg::SAMPLE_W-1:0] y, cb, cr,
			input logic [yuvrot_pkg::POS_W-1:0] col, row);
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		luma <= y;
		chroma_blue <= cb;
		chroma_red <= cr;
		src_col <= col;
		src_row <= row;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input yuvrot_pkg::reg_idx_t idx,
			input logic [yuvrot_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Wait for the block to drain, then load all three registers.
	task automatic load_frame(input yuvrot_pkg::rot_t rot, input int w, input int h);
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (LATENCY + 2) @(posedge clk);
		write_reg(yuvrot_pkg::REG_ROTATION, {{(yuvrot_pkg::CFG_W-2){1'b0}}, rot});
		write_reg(yuvrot_pkg::REG_SRC_WIDTH, w[yuvrot_pkg::CFG_W-1:0]);
		write_reg(yuvrot_pkg::REG_SRC_HEIGHT, h[yuvrot_pkg::CFG_W-1:0]);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	// Random pixel words, split over the four idling modes.
	task automatic run_stream(input int count);
		int idle_pct[4];
		int stall_pct[4];
		idle_pct = '{0, 72, 0, 34};
		stall_pct = '{0, 0, 72, 34};
		for (int k = 0; k < 4; k++) begin
			sender_idle = idle_pct[k];
			recv_stall = stall_pct[k];
			for (int i = 0; i < count / 4; i++) begin
				send_pixel(pick_sample(), pick_sample(), pick_sample(),
					pick_pos(cur_w), pick_pos(cur_h));
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset frame of 240 by 240 with no rotation.
		send_pixel(8'd16, 8'd128, 8'd128, 10'd0, 10'd0);
		send_pixel(8'd0, 8'd128, 8'd128, 10'd0, 10'd0);
		send_pixel(8'd255, 8'd128, 8'd128, 10'd239, 10'd239);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd0, 10'd239);
		send_pixel(8'd0, 8'd0, 8'd0, 10'd239, 10'd0);
		send_pixel(8'd255, 8'd0, 8'd255, 10'd1, 10'd2);
		send_pixel(8'd0, 8'd255, 8'd0, 10'd100, 10'd50);
		send_pixel(8'd128, 8'd0, 8'd255, 10'd120, 10'd7);
		send_pixel(8'd235, 8'd240, 8'd16, 10'd17, 10'd230);
		send_pixel(8'd81, 8'd90, 8'd240, 10'd100, 10'd200);
		// Positions just past each edge and at the far corner lie outside the frame.
		send_pixel(8'd128, 8'd128, 8'd128, 10'd240, 10'd0);
		send_pixel(8'd128, 8'd128, 8'd128, 10'd0, 10'd240);
		send_pixel(8'd128, 8'd128, 8'd128, 10'd1023, 10'd1023);
		send_pixel(8'd200, 8'd50, 8'd60, 10'd1023, 10'd0);
		run_stream(PHASE_WORDS);

		// Largest frame, with a long output hold-off at the start.
		load_frame(yuvrot_pkg::ROT_90, 1024, 1024);
		hold_seq++;
		run_stream(PHASE_WORDS);
		load_frame(yuvrot_pkg::ROT_180, 2, 2);
		run_stream(PHASE_WORDS);
		// Oversized width saturates; zero height puts every position outside.
		load_frame(yuvrot_pkg::ROT_270, 2047, 0);
		run_stream(PHASE_WORDS);
		// Odd width is used as given.
		load_frame(yuvrot_pkg::ROT_90, 37, 1000);
		run_stream(PHASE_WORDS);
		load_frame(yuvrot_pkg::ROT_270, 640, 480);
		run_stream(PHASE_WORDS);
		load_frame(yuvrot_pkg::ROT_180, 1024, 2);
		run_stream(PHASE_WORDS);
		load_frame(yuvrot_pkg::ROT_NONE, 0, 1024);
		run_stream(PHASE_WORDS);
		load_frame(yuvrot_pkg::ROT_NONE, 1024, 1100);
		run_stream(PHASE_WORDS);
		for (int p = 0; p < 5; p++) begin
			load_frame(yuvrot_pkg::rot_t'($urandom_range(3)), pick_dim(), pick_dim());
			run_stream(PHASE_WORDS);
		end

		// Drain and report.
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (4 * LATENCY) @(posedge clk);
		if (fail_count == 0) begin
			$display("[yuv420_to_rgb565_rotate] OK");
		end else begin
			$display("[yuv420_to_rgb565_rotate] ERROR");
		end
		$finish;
	end

endmodule
